### design/i2c_master_byte_engine_core_defines.svh
// Assertion macros for the I2C master byte engine checker.
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH

// Immediate implication: the consequent holds at the same edge.
`define I2CM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent holds at the following edge.
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PHASE_W    = 2;
    localparam int unsigned BITCNT_W   = 4;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 16;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;
    localparam logic [QUEUE_CNT_W-1:0] QUEUE_DEPTH = 2'd2;

    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [BYTE_W-1:0]   ACK_TIMEOUT_RESET = 8'd21;
    localparam logic [BYTE_W-1:0]   MSB_MASK = 8'h80;

    typedef enum logic [CMD_W-1:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_WRITE     = 3'd2,
        CMD_READ_ACK  = 3'd3,
        CMD_READ_NACK = 3'd4,
        CMD_IDLE      = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BUS_BUSY = 2'd1,
        ST_NO_ACK   = 2'd2
    } t_status;

    // What the back end does with a queued request.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_NOP  = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        t_cmd              cmd;
        logic [BYTE_W-1:0] data;
        logic              sda;
    } t_req;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        t_status           status;
        logic [BYTE_W-1:0] rbyte;
    } t_res;

endpackage

### design/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine.
// Each request on the slave stream is either a delay tick (tuser 0), carrying the
// sampled SDA level, or a command (tuser 1: start, stop, write byte, read with ack,
// read with nack), and produces exactly one result on the master stream with the
// SCL/SDA levels to drive, busy, done, status and the received byte. The engine
// sustains one request per clock while results are taken; each request passes through
// the two-entry request queue and then the result register before its result appears.
// The queue lets the input keep flowing while a result waits to be taken. The
// ack_timeout register (reset 21) is written through the cfg channel, which is
// always ready; write it only while no request is in flight.
`timescale 1ns / 1ps

module i2c_master_byte_engine_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [2:0] command, [10:3] data_byte, [11] sda_in, [15:12] zero
    input  logic [i2cm_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] kind
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res, [5:4] status,
    // [13:6] read_byte, [15:14] zero
    output logic [i2cm_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [i2cm_pkg::BYTE_W-1:0]    i_cfg_data
);
    import i2cm_pkg::*;

    logic [BYTE_W-1:0] r_ack_timeout;
    logic              s_q_full;
    logic              s_push;
    t_req              s_front_req;
    logic              s_q_valid;
    logic              s_pop;
    t_req              s_q_req;
    logic              s_res_valid;
    t_res              s_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ack_timeout <= i_cfg_data;
        end
    end

    i2cm_front u_front (
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser),
        .i_command   (i_s_axis_tdata[2:0]),
        .i_data_byte (i_s_axis_tdata[10:3]),
        .i_sda_in    (i_s_axis_tdata[11]),
        .i_q_full    (s_q_full),
        .o_push      (s_push),
        .o_req       (s_front_req)
    );

    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_req   (s_front_req),
        .o_full  (s_q_full),
        .o_valid (s_q_valid),
        .i_pop   (s_pop),
        .o_req   (s_q_req)
    );

    i2cm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_q_valid),
        .i_req         (s_q_req),
        .o_pop         (s_pop),
        .i_ack_timeout (r_ack_timeout),
        .o_res_valid   (s_res_valid),
        .i_res_ready   (i_m_axis_tready),
        .o_res         (s_res)
    );

    assign o_m_axis_tvalid = s_res_valid;
    assign o_m_axis_tdata  = {2'b00, s_res.rbyte, s_res.status, s_res.done,
                              s_res.busy, s_res.sda, s_res.scl};

endmodule

### design/i2cm_front.sv
// Front end: takes stream requests and classifies them for the queue.
`timescale 1ns / 1ps

module i2cm_front (
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_kind,
    input  logic [i2cm_pkg::CMD_W-1:0]  i_command,
    input  logic [i2cm_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                      i_sda_in,
    input  logic                      i_q_full,
    output logic                      o_push,
    output i2cm_pkg::t_req            o_req
);
    import i2cm_pkg::*;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_req.cmd  = CMD_IDLE;
        o_req.data = i_data_byte;
        o_req.sda  = i_sda_in;
        if (!i_kind) begin
            o_req.op = OP_TICK;
        end else if (i_command <= CMD_READ_NACK) begin
            o_req.op  = OP_LOAD;
            o_req.cmd = t_cmd'(i_command);
        end else begin
            // unknown code: report the lines, change nothing
            o_req.op = OP_NOP;
        end
    end

endmodule

### design/i2cm_queue.sv
// Two-entry request queue between the front and back ends.
`timescale 1ns / 1ps

module i2cm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  i2cm_pkg::t_req i_req,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output i2cm_pkg::t_req o_req
);
    import i2cm_pkg::*;

    t_req                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign o_full  = (r_count == QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

### design/i2cm_back.sv
// Back end: bus phase sequencer and registered result.
`timescale 1ns / 1ps

module i2cm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  i2cm_pkg::t_req              i_req,
    output logic                        o_pop,
    input  logic [i2cm_pkg::BYTE_W-1:0] i_ack_timeout,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output i2cm_pkg::t_res              o_res
);
    import i2cm_pkg::*;

    t_cmd                r_cmd,    n_cmd;
    logic [PHASE_W-1:0]  r_phase,  n_phase;
    logic [BITCNT_W-1:0] r_bits,   n_bits;
    logic [BYTE_W-1:0]   r_shift,  n_shift;
    logic [BYTE_W-1:0]   r_ackcnt, n_ackcnt;
    logic                r_scl,    n_scl;
    logic                r_sda,    n_sda;
    logic                r_out_valid;
    t_res                r_res;
    t_res                s_res;
    logic                s_finish;
    t_status             s_status;
    logic [BYTE_W-1:0]   s_rbyte;

    // Advance on a queued request whenever the result register is free or being emptied.
    assign o_pop       = i_valid && (!r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    always_comb begin
        n_cmd    = r_cmd;
        n_phase  = r_phase;
        n_bits   = r_bits;
        n_shift  = r_shift;
        n_ackcnt = r_ackcnt;
        n_scl    = r_scl;
        n_sda    = r_sda;
        s_finish = 1'b0;
        s_status = ST_OK;
        s_rbyte  = '0;
        unique case (i_req.op)
            OP_LOAD: begin
                n_cmd    = i_req.cmd;
                n_phase  = '0;
                n_bits   = '0;
                n_ackcnt = '0;
                n_shift  = (i_req.cmd == CMD_WRITE) ? i_req.data : '0;
            end
            OP_TICK: begin
                unique case (r_cmd) inside
                    CMD_START: begin
                        case (r_phase)
                            2'd0: begin
                                n_sda   = 1'b1;
                                n_phase = 2'd1;
                            end
                            2'd1: begin
                                n_scl   = 1'b1;
                                n_phase = 2'd2;
                            end
                            2'd2: begin
                                if (!i_req.sda) begin
                                    s_status = ST_BUS_BUSY;
                                    s_finish = 1'b1;
                                end else begin
                                    n_sda   = 1'b0;
                                    n_phase = 2'd3;
                                end
                            end
                            default: begin
                                if (i_req.sda) begin
                                    s_status = ST_BUS_BUSY;
                                end else begin
                                    n_scl = 1'b0;
                                end
                                s_finish = 1'b1;
                            end
                        endcase
                    end
                    CMD_STOP: begin
                        case (r_phase)
                            2'd0: begin
                                n_scl   = 1'b0;
                                n_sda   = 1'b0;
                                n_phase = 2'd1;
                            end
                            2'd1: begin
                                n_scl   = 1'b1;
                                n_phase = 2'd2;
                            end
                            default: begin
                                n_sda    = 1'b1;
                                s_finish = 1'b1;
                            end
                        endcase
                    end
                    CMD_WRITE: begin
                        if (r_bits < BITS_PER_BYTE) begin
                            case (r_phase)
                                2'd0: begin
                                    n_scl   = 1'b0;
                                    n_sda   = |(r_shift & MSB_MASK);
                                    n_phase = 2'd1;
                                end
                                2'd1: begin
                                    n_scl   = 1'b1;
                                    n_phase = 2'd2;
                                end
                                default: begin
                                    n_scl   = 1'b0;
                                    n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                                    n_bits  = r_bits + 1'b1;
                                    n_phase = '0;
                                end
                            endcase
                        end else begin
                            case (r_phase)
                                2'd0: begin
                                    n_sda   = 1'b1;
                                    n_phase = 2'd1;
                                end
                                2'd1: begin
                                    n_scl   = 1'b1;
                                    n_phase = 2'd2;
                                end
                                default: begin
                                    if (!i_req.sda) begin
                                        n_scl    = 1'b0;
                                        s_finish = 1'b1;
                                    end else if (r_ackcnt >= i_ack_timeout) begin
                                        n_scl    = 1'b0;
                                        s_status = ST_NO_ACK;
                                        s_finish = 1'b1;
                                    end else begin
                                        n_ackcnt = r_ackcnt + 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    CMD_READ_ACK, CMD_READ_NACK: begin
                        if (r_bits < BITS_PER_BYTE) begin
                            if (r_phase == '0) begin
                                n_scl   = 1'b1;
                                n_sda   = 1'b1;
                                n_phase = 2'd1;
                            end else begin
                                n_shift = {r_shift[BYTE_W-2:0], i_req.sda};
                                n_scl   = 1'b0;
                                n_bits  = r_bits + 1'b1;
                                n_phase = '0;
                            end
                        end else begin
                            case (r_phase)
                                2'd0: begin
                                    n_scl   = 1'b0;
                                    n_phase = 2'd1;
                                end
                                2'd1: begin
                                    n_sda   = (r_cmd == CMD_READ_NACK);
                                    n_phase = 2'd2;
                                end
                                2'd2: begin
                                    n_scl   = 1'b1;
                                    n_phase = 2'd3;
                                end
                                default: begin
                                    n_scl    = 1'b0;
                                    s_rbyte  = r_shift;
                                    s_finish = 1'b1;
                                end
                            endcase
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        if (s_finish) begin
            n_cmd    = CMD_IDLE;
            n_phase  = '0;
            n_bits   = '0;
            n_ackcnt = '0;
        end
    end

    always_comb begin
        s_res.scl    = n_scl;
        s_res.sda    = n_sda;
        s_res.busy   = (n_cmd != CMD_IDLE);
        s_res.done   = s_finish;
        s_res.status = s_status;
        s_res.rbyte  = s_rbyte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CMD_IDLE;
            r_phase     <= '0;
            r_bits      <= '0;
            r_shift     <= '0;
            r_ackcnt    <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cmd       <= n_cmd;
                r_phase     <= n_phase;
                r_bits      <= n_bits;
                r_shift     <= n_shift;
                r_ackcnt    <= n_ackcnt;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= s_res;
        end
    end

endmodule

### design/i2cm_checker.sv
// Port-level assertion checker for the I2C master byte engine, with its bind.
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_core_defines.svh"

module i2cm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [i2cm_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import i2cm_pkg::*;

    logic s_busy;
    logic s_done;
    logic [STATUS_W-1:0] s_status;
    logic [BYTE_W-1:0]   s_rbyte;

    assign s_busy   = o_m_axis_tdata[2];
    assign s_done   = o_m_axis_tdata[3];
    assign s_status = o_m_axis_tdata[5:4];
    assign s_rbyte  = o_m_axis_tdata[13:6];

    // a finished sequence always leaves the engine idle
    `I2CM_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, o_m_axis_tvalid && s_done, !s_busy, "done with busy set")
    // status and received byte only accompany a finished sequence
    `I2CM_ASSERT_NOW(a_status_on_done, i_clk, i_rst_n, o_m_axis_tvalid && !s_done, s_status == ST_OK && s_rbyte == '0, "status or byte without done")
    // a failure never reports a received byte
    `I2CM_ASSERT_NOW(a_fail_no_byte, i_clk, i_rst_n, o_m_axis_tvalid && s_status != ST_OK, s_rbyte == '0, "byte reported on failure")
    // a stalled result holds
    `I2CM_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

endmodule

bind i2c_master_byte_engine_core i2cm_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

### sim/i2cm_bus_checker.sv
// Checker for the I2C byte engine: predicts each result from the requests and compares.
`timescale 1ns / 1ps

module i2cm_bus_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    // [2:0] command, [10:3] data_byte, [11] sda_in, [15:12] zero
    input  logic [i2cm_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] kind
    input  logic                           i_s_axis_tuser,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res, [5:4] status,
    // [13:6] read_byte, [15:14] zero
    input  logic [i2cm_pkg::M_TDATA_W-1:0] i_m_axis_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [i2cm_pkg::BYTE_W-1:0]    i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import i2cm_pkg::*;

    t_cmd                 bus_cmd;
    logic [4:0]           bus_step;
    logic [BITCNT_W-1:0]  bus_bits;
    logic [BYTE_W-1:0]    bus_shift;
    logic [BYTE_W-1:0]    ack_ticks;
    logic [BYTE_W-1:0]    ack_limit;
    logic                 scl_lvl;
    logic                 sda_lvl;
    logic [M_TDATA_W-1:0] bus_result_q[$];
    int                   mismatch_cnt;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatch_cnt = 0;
    end

    // Advance the predicted bus engine by one request and return the packed result.
    function automatic logic [M_TDATA_W-1:0] advance_bus(logic is_cmd, logic [CMD_W-1:0] code,
                                                         logic [BYTE_W-1:0] data,
                                                         logic sda_in);
        logic              finish;
        t_status           st;
        logic [BYTE_W-1:0] rbyte;
        finish = 1'b0;
        st     = ST_OK;
        rbyte  = '0;
        if (is_cmd) begin
            // unknown codes leave everything as it stands
            if (code <= CMD_READ_NACK) begin
                bus_cmd   = t_cmd'(code);
                bus_step  = '0;
                bus_bits  = '0;
                ack_ticks = '0;
                bus_shift = (code == CMD_WRITE) ? data : '0;
            end
        end else begin
            case (bus_cmd)
                CMD_START: begin
                    case (bus_step)
                        5'd0: begin
                            sda_lvl  = 1'b1;
                            bus_step = 5'd1;
                        end
                        5'd1: begin
                            scl_lvl  = 1'b1;
                            bus_step = 5'd2;
                        end
                        5'd2: begin
                            if (!sda_in) begin
                                st     = ST_BUS_BUSY;
                                finish = 1'b1;
                            end else begin
                                sda_lvl  = 1'b0;
                                bus_step = 5'd3;
                            end
                        end
                        default: begin
                            // SDA still high means another master holds the bus
                            if (sda_in) begin
                                st = ST_BUS_BUSY;
                            end else begin
                                scl_lvl = 1'b0;
                            end
                            finish = 1'b1;
                        end
                    endcase
                end
                CMD_STOP: begin
                    case (bus_step)
                        5'd0: begin
                            scl_lvl  = 1'b0;
                            sda_lvl  = 1'b0;
                            bus_step = 5'd1;
                        end
                        5'd1: begin
                            scl_lvl  = 1'b1;
                            bus_step = 5'd2;
                        end
                        default: begin
                            sda_lvl = 1'b1;
                            finish  = 1'b1;
                        end
                    endcase
                end
                CMD_WRITE: begin
                    if (bus_bits < BITS_PER_BYTE) begin
                        case (bus_step)
                            5'd0: begin
                                scl_lvl  = 1'b0;
                                sda_lvl  = bus_shift[BYTE_W-1];
                                bus_step = 5'd1;
                            end
                            5'd1: begin
                                scl_lvl  = 1'b1;
                                bus_step = 5'd2;
                            end
                            default: begin
                                scl_lvl   = 1'b0;
                                bus_shift = bus_shift << 1;
                                bus_bits  = bus_bits + 1'b1;
                                bus_step  = 5'd0;
                            end
                        endcase
                    end else begin
                        case (bus_step)
                            5'd0: begin
                                sda_lvl  = 1'b1;
                                bus_step = 5'd1;
                            end
                            5'd1: begin
                                scl_lvl  = 1'b1;
                                bus_step = 5'd2;
                            end
                            default: begin
                                if (!sda_in) begin
                                    scl_lvl = 1'b0;
                                    finish  = 1'b1;
                                end else if (ack_ticks >= ack_limit) begin
                                    scl_lvl = 1'b0;
                                    st      = ST_NO_ACK;
                                    finish  = 1'b1;
                                end else begin
                                    ack_ticks = ack_ticks + 1'b1;
                                end
                            end
                        endcase
                    end
                end
                CMD_READ_ACK, CMD_READ_NACK: begin
                    if (bus_bits < BITS_PER_BYTE) begin
                        if (bus_step == 5'd0) begin
                            scl_lvl  = 1'b1;
                            sda_lvl  = 1'b1;
                            bus_step = 5'd1;
                        end else begin
                            bus_shift = {bus_shift[BYTE_W-2:0], sda_in};
                            scl_lvl   = 1'b0;
                            bus_bits  = bus_bits + 1'b1;
                            bus_step  = 5'd0;
                        end
                    end else begin
                        case (bus_step)
                            5'd0: begin
                                scl_lvl  = 1'b0;
                                bus_step = 5'd1;
                            end
                            5'd1: begin
                                sda_lvl  = (bus_cmd == CMD_READ_NACK);
                                bus_step = 5'd2;
                            end
                            5'd2: begin
                                scl_lvl  = 1'b1;
                                bus_step = 5'd3;
                            end
                            default: begin
                                scl_lvl = 1'b0;
                                rbyte   = bus_shift;
                                finish  = 1'b1;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
        if (finish) begin
            bus_cmd   = CMD_IDLE;
            bus_step  = '0;
            bus_bits  = '0;
            ack_ticks = '0;
        end
        return {{(M_TDATA_W-14){1'b0}}, rbyte, st, finish, bus_cmd != CMD_IDLE,
                sda_lvl, scl_lvl};
    endfunction

    task automatic report_mismatch(string what, logic [M_TDATA_W-1:0] exp_word,
                                   logic [M_TDATA_W-1:0] act_word);
        o_fail_count++;
        if (mismatch_cnt < 10) begin
            $display("[%0t] %s: scl %b/%b sda %b/%b busy %b/%b done %b/%b status %0d/%0d",
                     $time, what, exp_word[0], act_word[0], exp_word[1], act_word[1],
                     exp_word[2], act_word[2], exp_word[3], act_word[3],
                     exp_word[5:4], act_word[5:4]);
            $display("    read_byte %h/%h pad %b/%b (expected/actual)",
                     exp_word[13:6], act_word[13:6], exp_word[15:14], act_word[15:14]);
        end
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        logic [M_TDATA_W-1:0] exp_word;
        if (!i_rst_n) begin
            bus_cmd   = CMD_IDLE;
            bus_step  = '0;
            bus_bits  = '0;
            bus_shift = '0;
            ack_ticks = '0;
            ack_limit = ACK_TIMEOUT_RESET;
            scl_lvl   = 1'b1;
            sda_lvl   = 1'b1;
            bus_result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                ack_limit = i_cfg_data;
            end
            // pop before push: a result taken now belongs to an older request
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (bus_result_q.size() == 0) begin
                    report_mismatch("result with no request outstanding", '0, i_m_axis_tdata);
                end else begin
                    exp_word = bus_result_q.pop_front();
                    if (i_m_axis_tdata[0] !== exp_word[0] || i_m_axis_tdata[1] !== exp_word[1]
                        || i_m_axis_tdata[2] !== exp_word[2]
                        || i_m_axis_tdata[3] !== exp_word[3]
                        || i_m_axis_tdata[5:4] !== exp_word[5:4]
                        || i_m_axis_tdata[13:6] !== exp_word[13:6]
                        || i_m_axis_tdata[15:14] !== exp_word[15:14]) begin
                        report_mismatch("result mismatch", exp_word, i_m_axis_tdata);
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                bus_result_q.push_back(advance_bus(i_s_axis_tuser, i_s_axis_tdata[2:0],
                                                   i_s_axis_tdata[10:3], i_s_axis_tdata[11]));
            end
        end
        o_pending = bus_result_q.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top for the I2C master byte engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
    import i2cm_pkg::*;

    localparam logic KIND_TICK      = 1'b0;
    localparam logic KIND_CMD       = 1'b1;
    localparam int   PHASE_ITEMS    = 400;
    localparam int   HOLD_AT        = 700;
    localparam int   HOLD_CYCLES    = 400;
    localparam int   SETTLE_CYCLES  = 8;
    localparam int   WATCHDOG_LIMIT = 3000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    int fail_count;
    int pending;
    int idle_cycles  = 0;
    int sent_count   = 0;
    int useful_count = 0;
    int burst_left   = 0;
    int cur_limit    = ACK_TIMEOUT_RESET;

    logic [BYTE_W-1:0] limit_plan [4] = '{8'd0, 8'd255, 8'd0, 8'd1};

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    i2c_master_byte_engine_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    i2cm_bus_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one request, opening a gap first when the current burst has run out.
    task automatic send_item(logic kind, logic [CMD_W-1:0] code, logic [BYTE_W-1:0] data,
                             logic sda, bit useful);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-12){1'b0}}, sda, data, code};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        sent_count++;
        if (useful) begin
            useful_count++;
        end
    endtask

    // Command and data fields are don't-care on a tick, so scramble them.
    task automatic tick(logic sda, bit useful);
        send_item(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), sda, useful);
    endtask

    task automatic send_cmd(logic [CMD_W-1:0] code, logic [BYTE_W-1:0] data);
        send_item(KIND_CMD, code, data, rnd_bit(), 1'b1);
    endtask

    // fault 0: clean start, 1: SDA low while SCL high, 2: SDA stays high once pulled low
    task automatic run_start(int fault);
        send_cmd(CMD_START, 8'($urandom_range(0, 255)));
        tick(rnd_bit(), 1'b1);
        tick(rnd_bit(), 1'b1);
        if (fault == 1) begin
            tick(1'b0, 1'b1);
        end else begin
            tick(1'b1, 1'b1);
            tick(fault == 2, 1'b1);
        end
    endtask

    task automatic run_stop();
        send_cmd(CMD_STOP, 8'($urandom_range(0, 255)));
        repeat (3) tick(rnd_bit(), 1'b1);
    endtask

    // Hold SDA high for high_ticks during the acknowledge wait; beyond the limit it times out.
    task automatic run_write(logic [BYTE_W-1:0] data, int high_ticks);
        int i;
        send_cmd(CMD_WRITE, data);
        repeat (26) tick(rnd_bit(), 1'b1);
        for (i = 0; i < high_ticks && i <= cur_limit; i++) begin
            tick(1'b1, 1'b1);
        end
        if (high_ticks <= cur_limit) begin
            tick(1'b0, 1'b1);
        end
    endtask

    function automatic int pick_ack_delay();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return cur_limit + 1;
        end else if (r == 1) begin
            return cur_limit;
        end
        return $urandom_range(0, (cur_limit < 5) ? cur_limit : 5);
    endfunction

    task automatic run_read(logic [CMD_W-1:0] code);
        send_cmd(code, 8'($urandom_range(0, 255)));
        repeat (20) tick(rnd_bit(), 1'b1);
    endtask

    // Leave a sequence possibly half done so that the next command cuts it short.
    task automatic run_fragment();
        send_cmd(3'($urandom_range(CMD_START, CMD_READ_NACK)), 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 12)) tick(rnd_bit(), 1'b1);
    endtask

    task automatic run_transaction();
        int fault;
        fault = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
        run_start(fault);
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
                0:       run_write(8'($urandom_range(0, 255)), pick_ack_delay());
                1:       run_read(CMD_READ_ACK);
                default: run_read(CMD_READ_NACK);
            endcase
        end
        run_stop();
    endtask

    task automatic run_directed();
        tick(1'b0, 1'b0);
        tick(1'b1, 1'b0);
        send_item(KIND_CMD, CMD_IDLE, 8'hFF, 1'b1, 1'b0);
        send_item(KIND_CMD, 3'(CMD_READ_NACK + 1), 8'h00, 1'b0, 1'b0);
        run_start(0);
        run_start(1);
        run_start(2);
        run_stop();
        // write cut short by a read, which a read with nack cuts short in turn
        send_cmd(CMD_WRITE, 8'hFF);
        repeat (4) tick(rnd_bit(), 1'b1);
        send_cmd(CMD_READ_ACK, 8'h00);
        repeat (2) tick(1'b1, 1'b1);
        send_cmd(CMD_READ_NACK, 8'h00);
        tick(1'b0, 1'b1);
    endtask

    task automatic run_random(int target);
        while (useful_count < target) begin
            case ($urandom_range(0, 19))
                0:       tick(rnd_bit(), 1'b0);
                1:       send_item(KIND_CMD, 3'($urandom_range(CMD_READ_NACK + 1, CMD_IDLE)),
                                   8'($urandom_range(0, 255)), rnd_bit(), 1'b0);
                2:       run_fragment();
                default: run_transaction();
            endcase
        end
    endtask

    // Drop valid and wait until every outstanding result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ack_limit(logic [BYTE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_limit = value;
    endtask

    initial begin
        int                target;
        int                ph;
        logic [BYTE_W-1:0] next_limit;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        target = PHASE_ITEMS;
        run_random(target);
        for (ph = 0; ph < 4; ph++) begin
            drain();
            next_limit = (ph == 2) ? 8'($urandom_range(2, 254)) : limit_plan[ph];
            write_ack_limit(next_limit);
            target += PHASE_ITEMS;
            run_random(target);
        end
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Result side: stall on a changing duty pattern, with one long hold-off to fill the block.
    initial begin
        int pct;
        int left;
        bit held;
        pct  = 100;
        left = 0;
        held = 1'b0;
        wait (rst_n);
        forever begin
            if (!held && sent_count >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                if (left == 0) begin
                    left = $urandom_range(16, 200);
                    case ($urandom_range(0, 3))
                        0:       pct = 100;
                        1:       pct = 80;
                        2:       pct = 50;
                        default: pct = 20;
                    endcase
                end
                left--;
                m_tready <= ($urandom_range(1, 100) <= pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb_top failed");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_queue.sv
design/i2cm_back.sv
design/i2c_master_byte_engine_core.sv
design/i2cm_checker.sv
sim/i2cm_bus_checker.sv
sim/tb_top.sv
